// File: rtl/core/ssd_block_match_disparity_assert.svh
// Assertion macros for the block-matching disparity core.
`ifndef SSD_BLOCK_MATCH_DISPARITY_ASSERT_SVH
`define SSD_BLOCK_MATCH_DISPARITY_ASSERT_SVH
`ifndef SYNTHESIS
`define SBMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sbmd: assertion failed");
`define SBMD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sbmd: assertion failed");
`else
`define SBMD_ASSERT(lbl, prop)
`define SBMD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/core/sbmd_pkg.sv
// Shared constants and types of the block-matching disparity core.
package sbmd_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxWindow  = 15;
  localparam int StoreDepth = MaxWindow * MaxWidth;
  localparam int ColW       = 6;
  localparam int SlotW      = 4;
  localparam int AddrW      = SlotW + ColW;
  localparam int PixW       = 8;
  localparam int IdxW       = 3;
  localparam int CfgDataW   = 7;
  localparam int AccW       = 28;
  localparam int ProdW      = 20;
  localparam int MeanW      = 10;
  localparam int DiffW      = 12;
  localparam int DvdW       = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_JSTART,
    ST_CSTART,
    ST_WALK,
    ST_DIV,
    ST_CMP,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    WK_SUM_L,
    WK_SUM_R,
    WK_SSD
  } walk_e;

  localparam logic [IdxW-1:0] RegImageWidth     = 3'd0;
  localparam logic [IdxW-1:0] RegWindowSize     = 3'd1;
  localparam logic [IdxW-1:0] RegMatchMode      = 3'd2;
  localparam logic [IdxW-1:0] RegDisparityScale = 3'd3;

endpackage

// File: rtl/core/sbmd_if.sv
// Stream and configuration channel interfaces of the block-matching disparity core.
interface sbmd_in_if;
  logic                       valid;
  logic                       ready;
  logic [sbmd_pkg::PixW-1:0]  left_pixel;
  logic [sbmd_pkg::PixW-1:0]  right_pixel;
  logic                       start_of_image;
  modport source (output valid, left_pixel, right_pixel, start_of_image, input ready);
  modport sink   (input valid, left_pixel, right_pixel, start_of_image, output ready);
endinterface

interface sbmd_out_if;
  logic                       valid;
  logic                       ready;
  logic [sbmd_pkg::PixW-1:0]  disparity;
  logic [sbmd_pkg::ColW-1:0]  centre_column;
  logic                       last_in_row;
  modport source (output valid, disparity, centre_column, last_in_row, input ready);
  modport sink   (input valid, disparity, centre_column, last_in_row, output ready);
endinterface

interface sbmd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sbmd_pkg::IdxW-1:0]     index;
  logic [sbmd_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ssd_block_match_disparity.sv
// Top level of the streaming SSD block-matching disparity core.
//
//   Channel | Direction | Beat contents
//   cfg_i   | in        | register index, write data
//   pix_i   | in        | left pixel, right pixel, start of image
//   disp_o  | out       | disparity, centre column, last in row
//
// A pixel beat that does not end a row is stored and leaves the block ready for the next.
// A beat that ends a row, once 2h+1 rows are stored and W > 2h, starts a search of
// N = W-2h centre columns; each centre and candidate column pair runs one window walk
// of (2h+1)^2 pixels on the shared window walker, and in mode 1 a window sum and a divide per column.
// The block takes no pixel until the last disparity beat of the row is taken.
// Reset clears the counters and sets the configuration to its defaults; the row stores are not cleared.
`include "ssd_block_match_disparity_assert.svh"

module ssd_block_match_disparity (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbmd_cfg_if.sink    cfg_i,
  sbmd_in_if.sink     pix_i,
  sbmd_out_if.source  disp_o
);

  sbmd_pkg::state_e state_q, state_d;
  sbmd_pkg::walk_e  kind_q, kind_d;

  logic [6:0] width_q;
  logic [3:0] wsize_q;
  logic       mode_q;
  logic [3:0] scale_q;

  logic [sbmd_pkg::SlotW-1:0] ring_head_q;
  logic [sbmd_pkg::ColW-1:0]  cc_q;
  logic [15:0]                row_q;

  logic [sbmd_pkg::PixW-1:0] lmem [sbmd_pkg::StoreDepth];
  logic [sbmd_pkg::PixW-1:0] rmem [sbmd_pkg::StoreDepth];
  logic [sbmd_pkg::PixW-1:0] l_rd_q, r_rd_q;

  logic [sbmd_pkg::SlotW-1:0] proc_head_q, slot_q;
  logic [sbmd_pkg::ColW-1:0]  j_q, c_q, col_l_q, col_r_q, bestc_q;
  logic [3:0]                 r_q, k_q;
  logic                       issue_done_q, rd_vld_q, prod_vld_q;
  logic [sbmd_pkg::ProdW-1:0] prod_q;
  logic [sbmd_pkg::AccW-1:0]  acc_q, best_q;
  logic [sbmd_pkg::MeanW-1:0] ml_q, mr_q;
  logic [sbmd_pkg::DvdW-1:0]  dvd_q, quo_q;
  logic [7:0]                 rem_q;
  logic [4:0]                 dcnt_q;
  logic [sbmd_pkg::PixW-1:0]  out_disp_q;
  logic [sbmd_pkg::ColW-1:0]  out_col_q;
  logic                       out_last_q;

  logic       cfg_acc, in_acc, row_done, start_search;
  logic [6:0] w_eff;
  logic [2:0] h;
  logic [3:0] two_h;
  logic [7:0] div;
  logic [sbmd_pkg::SlotW-1:0] head_e;
  logic [sbmd_pkg::ColW-1:0]  cc_e;
  logic [15:0]                row_e;
  logic       walk_init, issuing, walk_done, div_last, better, c_last, j_last;
  logic [8:0] rem_sh;
  logic       ge;
  logic [7:0] rem_n;
  logic [sbmd_pkg::DvdW-1:0] quo_n;
  logic signed [sbmd_pkg::DiffW-1:0] diff_px, mean_diff, dval;
  logic signed [2*sbmd_pkg::DiffW-1:0] sq;
  logic [sbmd_pkg::ColW-1:0] fin_bestc, ad;
  logic [9:0] dv;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign pix_i.ready = (state_q == sbmd_pkg::ST_IDLE);
  assign in_acc      = pix_i.valid && pix_i.ready;

  assign w_eff = (width_q == 7'd0) ? 7'd1 :
                 (width_q > 7'(sbmd_pkg::MaxWidth)) ? 7'(sbmd_pkg::MaxWidth) : width_q;
  assign h     = wsize_q[3:1];
  assign two_h = {h, 1'b0};
  assign div   = (wsize_q == 4'd0) ? 8'd1 : 8'({4'd0, wsize_q} * {4'd0, wsize_q});

  assign head_e = pix_i.start_of_image ? '0 : ring_head_q;
  assign cc_e   = pix_i.start_of_image ? '0 : cc_q;
  assign row_e  = pix_i.start_of_image ? '0 : row_q;
  assign row_done     = ({1'b0, cc_e} + 7'd1) >= w_eff;
  assign start_search = (row_e >= {12'd0, two_h}) && (w_eff > {3'd0, two_h});

  assign issuing   = (state_q == sbmd_pkg::ST_WALK) && !issue_done_q;
  assign walk_done = (state_q == sbmd_pkg::ST_WALK) && issue_done_q && !rd_vld_q && !prod_vld_q;

  assign rem_sh   = {rem_q, dvd_q[sbmd_pkg::DvdW-1]};
  assign ge       = rem_sh >= {1'b0, div};
  assign rem_n    = ge ? 8'(rem_sh - {1'b0, div}) : rem_sh[7:0];
  assign quo_n    = {quo_q[sbmd_pkg::DvdW-2:0], ge};
  assign div_last = (state_q == sbmd_pkg::ST_DIV) && (dcnt_q == 5'd1);

  assign diff_px   = $signed({4'd0, l_rd_q}) - $signed({4'd0, r_rd_q});
  assign mean_diff = mode_q ? ($signed({2'd0, ml_q}) - $signed({2'd0, mr_q})) : '0;
  assign dval      = diff_px - mean_diff;
  assign sq        = dval * dval;

  assign better    = (c_q == {3'd0, h}) || (acc_q < best_q);
  assign c_last    = ({1'b0, c_q} + {4'd0, h} + 7'd1) >= w_eff;
  assign j_last    = ({1'b0, j_q} + {4'd0, h} + 7'd1) == w_eff;
  assign fin_bestc = better ? c_q : bestc_q;
  assign ad        = (fin_bestc >= j_q) ? (fin_bestc - j_q) : (j_q - fin_bestc);
  assign dv        = {4'd0, ad} * {6'd0, scale_q};

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    walk_init = 1'b0;
    case (state_q)
      sbmd_pkg::ST_IDLE: begin
        if (in_acc && row_done && start_search) state_d = sbmd_pkg::ST_JSTART;
      end
      sbmd_pkg::ST_JSTART: begin
        if (mode_q) begin
          state_d   = sbmd_pkg::ST_WALK;
          kind_d    = sbmd_pkg::WK_SUM_L;
          walk_init = 1'b1;
        end else begin
          state_d = sbmd_pkg::ST_CSTART;
        end
      end
      sbmd_pkg::ST_CSTART: begin
        state_d   = sbmd_pkg::ST_WALK;
        kind_d    = mode_q ? sbmd_pkg::WK_SUM_R : sbmd_pkg::WK_SSD;
        walk_init = 1'b1;
      end
      sbmd_pkg::ST_WALK: begin
        if (walk_done) begin
          state_d = (kind_q == sbmd_pkg::WK_SSD) ? sbmd_pkg::ST_CMP : sbmd_pkg::ST_DIV;
        end
      end
      sbmd_pkg::ST_DIV: begin
        if (div_last) begin
          if (kind_q == sbmd_pkg::WK_SUM_L) begin
            state_d = sbmd_pkg::ST_CSTART;
          end else begin
            state_d   = sbmd_pkg::ST_WALK;
            kind_d    = sbmd_pkg::WK_SSD;
            walk_init = 1'b1;
          end
        end
      end
      sbmd_pkg::ST_CMP: begin
        state_d = c_last ? sbmd_pkg::ST_OUT : sbmd_pkg::ST_CSTART;
      end
      sbmd_pkg::ST_OUT: begin
        if (disp_o.ready) state_d = out_last_q ? sbmd_pkg::ST_IDLE : sbmd_pkg::ST_JSTART;
      end
      default: state_d = sbmd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbmd_pkg::ST_IDLE;
      kind_q      <= sbmd_pkg::WK_SSD;
      width_q     <= 7'd64;
      wsize_q     <= 4'd3;
      mode_q      <= 1'b0;
      scale_q     <= 4'd2;
      ring_head_q <= '0;
      cc_q        <= '0;
      row_q       <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      rd_vld_q   <= issuing;
      prod_vld_q <= rd_vld_q;
      if (cfg_acc) begin
        case (cfg_i.index)
          sbmd_pkg::RegImageWidth:     width_q <= cfg_i.data;
          sbmd_pkg::RegWindowSize:     wsize_q <= cfg_i.data[3:0];
          sbmd_pkg::RegMatchMode:      mode_q  <= cfg_i.data[0];
          sbmd_pkg::RegDisparityScale: scale_q <= cfg_i.data[3:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (row_done) begin
          cc_q        <= '0;
          ring_head_q <= (head_e == 4'(sbmd_pkg::MaxWindow - 1)) ? '0 : head_e + 4'd1;
          row_q       <= (row_e == 16'hFFFF) ? row_e : row_e + 16'd1;
        end else begin
          cc_q        <= cc_e + 6'd1;
          ring_head_q <= head_e;
          row_q       <= row_e;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lmem[{head_e, cc_e}] <= pix_i.left_pixel;
      rmem[{head_e, cc_e}] <= pix_i.right_pixel;
    end
    l_rd_q <= lmem[{slot_q, col_l_q}];
    r_rd_q <= rmem[{slot_q, col_r_q}];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && row_done) begin
      proc_head_q <= head_e;
      j_q         <= {3'd0, h};
    end
    if (state_q == sbmd_pkg::ST_JSTART) c_q <= {3'd0, h};
    if (walk_init) begin
      r_q          <= '0;
      k_q          <= '0;
      slot_q       <= proc_head_q;
      col_l_q      <= j_q - {3'd0, h};
      col_r_q      <= c_q - {3'd0, h};
      issue_done_q <= 1'b0;
      acc_q        <= '0;
    end else begin
      if (issuing) begin
        if (k_q == two_h) begin
          k_q     <= '0;
          col_l_q <= j_q - {3'd0, h};
          col_r_q <= c_q - {3'd0, h};
          r_q     <= r_q + 4'd1;
          slot_q  <= (slot_q == '0) ? 4'(sbmd_pkg::MaxWindow - 1) : slot_q - 4'd1;
          if (r_q == two_h) issue_done_q <= 1'b1;
        end else begin
          k_q     <= k_q + 4'd1;
          col_l_q <= col_l_q + 6'd1;
          col_r_q <= col_r_q + 6'd1;
        end
      end
      if (prod_vld_q) acc_q <= acc_q + {8'd0, prod_q};
    end
    if (rd_vld_q) begin
      case (kind_q)
        sbmd_pkg::WK_SUM_L: prod_q <= {12'd0, l_rd_q};
        sbmd_pkg::WK_SUM_R: prod_q <= {12'd0, r_rd_q};
        default:            prod_q <= sq[sbmd_pkg::ProdW-1:0];
      endcase
    end
    if (walk_done && kind_q != sbmd_pkg::WK_SSD) begin
      dvd_q  <= acc_q[sbmd_pkg::DvdW-1:0];
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= 5'd16;
    end else if (state_q == sbmd_pkg::ST_DIV) begin
      dvd_q  <= {dvd_q[sbmd_pkg::DvdW-2:0], 1'b0};
      rem_q  <= rem_n;
      quo_q  <= quo_n;
      dcnt_q <= dcnt_q - 5'd1;
      if (div_last) begin
        if (kind_q == sbmd_pkg::WK_SUM_L) ml_q <= quo_n[sbmd_pkg::MeanW-1:0];
        else mr_q <= quo_n[sbmd_pkg::MeanW-1:0];
      end
    end
    if (state_q == sbmd_pkg::ST_CMP) begin
      if (better) begin
        best_q  <= acc_q;
        bestc_q <= c_q;
      end
      if (c_last) begin
        out_disp_q <= (dv > 10'd255) ? 8'd255 : dv[7:0];
        out_col_q  <= j_q;
        out_last_q <= j_last;
      end else begin
        c_q <= c_q + 6'd1;
      end
    end
    if (state_q == sbmd_pkg::ST_OUT && disp_o.ready) j_q <= j_q + 6'd1;
  end

  assign disp_o.valid         = (state_q == sbmd_pkg::ST_OUT);
  assign disp_o.disparity     = out_disp_q;
  assign disp_o.centre_column = out_col_q;
  assign disp_o.last_in_row   = out_last_q;

  `SBMD_ASSERT(a_out_blocks_in, disp_o.valid |-> !pix_i.ready)
  `SBMD_ASSERT(a_ring_in_range, ring_head_q < 4'(sbmd_pkg::MaxWindow))
  `SBMD_ASSERT(a_last_ends_row, (disp_o.valid && disp_o.ready && disp_o.last_in_row) |=> (state_q == sbmd_pkg::ST_IDLE))
  `SBMD_ASSERT(a_cmp_col_valid, (state_q == sbmd_pkg::ST_CMP) |-> (({1'b0, c_q} + {4'd0, h}) < w_eff))

endmodule
